// ----- design/spcr_pkg.sv -----
// Shared types, constants and helper functions of the spherical camera ray generator.
`default_nettype none
package spcr_pkg;

	localparam int CoordBitsDef = 16;
	localparam int QBits        = 18;
	localparam int RootBits     = 17;

	localparam logic [17:0] NormMax = 18'h3FFFF;
	localparam logic [16:0] OneQ16  = 17'h10000;
	localparam logic [16:0] SinC1   = 17'd102944;
	localparam logic [16:0] SinC3   = 17'd42334;
	localparam logic [16:0] SinC5   = 17'd5223;
	localparam logic [16:0] SinC7   = 17'd297;

	typedef enum logic [2:0] {
		ModeHemi       = 3'd0,
		ModeSphere     = 3'd1,
		ModePanoHemi   = 3'd2,
		ModePanoSphere = 3'd3,
		ModeDefault    = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		RegMode       = 3'd0,
		RegWidth      = 3'd1,
		RegHeight     = 3'd2,
		RegWinX       = 3'd3,
		RegWinY       = 3'd4,
		RegMotionBlur = 3'd5,
		RegSpectral   = 3'd6
	} cfg_reg_t;

	// Everything one pixel sample carries down the pipeline.
	typedef struct packed {
		logic [15:0]      px;
		logic [15:0]      py;
		logic [15:0]      tsamp;
		logic [16:0]      wsamp;
		logic [32:0]      num_x;
		logic [32:0]      num_y;
		logic [17:0]      xn;
		logic [17:0]      yn;
		logic             back;
		logic             oob;
		logic [17:0]      xw;
		logic [17:0]      yw;
		logic [3:0]       neg;
		logic [3:0][16:0] z;
		logic [3:0][16:0] z2;
		logic [3:0][16:0] p;
		logic [3:0][17:0] sn;
		logic [31:0]      sqx;
		logic [31:0]      sqy;
		logic             in_disc;
		logic [32:0]      rad;
		logic [35:0]      prod_x;
		logic [35:0]      prod_y;
		logic [16:0]      zw;
	} spcr_item_t;

	// Splits an angle in Q0.17 turns into a quarter-wave argument and a sign.
	function automatic logic [17:0] turn_reduce(input logic [16:0] a);
		logic [16:0] f;
		logic [16:0] z;
		f = {1'b0, a[14:0], 1'b0};
		z = a[15] ? 17'(OneQ16 - f) : f;
		return {a[16], z};
	endfunction

	function automatic logic [15:0] sat_q15(input logic signed [23:0] v);
		logic [15:0] r;
		if (v > 24'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -24'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/spcr_div.sv -----
// Pipelined restoring divider producing the saturated Q2.16 normalized coordinates.
`default_nettype none
module spcr_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  spcr_pkg::spcr_item_t     in_item,
	input  wire logic [15:0]         size_x,
	input  wire logic [15:0]         size_y,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output spcr_pkg::spcr_item_t     out_item
);
	import spcr_pkg::*;

	localparam int Depth = QBits + 1;

	logic [Depth-1:0] vld_s;
	logic [Depth-1:0] en;
	spcr_item_t       itm_s [Depth];
	logic [15:0]      remx_s [Depth];
	logic [15:0]      remy_s [Depth];
	logic [QBits-1:0] qx_s [Depth];
	logic [QBits-1:0] qy_s [Depth];
	logic             satx_s [Depth];
	logic             saty_s [Depth];

	always_comb begin
		en[Depth-1] = !vld_s[Depth-1] || out_ready;
		for (int k = Depth - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < Depth; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// The quotient overflows 18 bits exactly when the top numerator bits reach the divisor.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			itm_s[0]  <= in_item;
			satx_s[0] <= {1'b0, in_item.num_x[32:QBits]} >= size_x;
			saty_s[0] <= {1'b0, in_item.num_y[32:QBits]} >= size_y;
			remx_s[0] <= {1'b0, in_item.num_x[32:QBits]};
			remy_s[0] <= {1'b0, in_item.num_y[32:QBits]};
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k < Depth; k++) begin : g_bit
		localparam int Bit = QBits - k;
		logic [16:0] tx;
		logic [16:0] ty;
		logic        gex;
		logic        gey;

		assign tx  = {remx_s[k-1], itm_s[k-1].num_x[Bit]};
		assign ty  = {remy_s[k-1], itm_s[k-1].num_y[Bit]};
		assign gex = tx >= {1'b0, size_x};
		assign gey = ty >= {1'b0, size_y};

		always_ff @(posedge clk) begin
			if (en[k]) begin
				itm_s[k]  <= itm_s[k-1];
				satx_s[k] <= satx_s[k-1];
				saty_s[k] <= saty_s[k-1];
				remx_s[k] <= gex ? 16'(tx - {1'b0, size_x}) : tx[15:0];
				remy_s[k] <= gey ? 16'(ty - {1'b0, size_y}) : ty[15:0];
				qx_s[k]   <= {qx_s[k-1][QBits-2:0], gex};
				qy_s[k]   <= {qy_s[k-1][QBits-2:0], gey};
			end
		end
	end

	assign out_valid = vld_s[Depth-1];

	always_comb begin
		out_item    = itm_s[Depth-1];
		out_item.xn = satx_s[Depth-1] ? NormMax : qx_s[Depth-1];
		out_item.yn = saty_s[Depth-1] ? NormMax : qy_s[Depth-1];
	end

	// The quotient must never exceed the numerator divided by the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !satx_s[Depth-1] |->
		(51'(qx_s[Depth-1]) * 51'(size_x) <= 51'(itm_s[Depth-1].num_x)))
		else $error("divider quotient too large");

endmodule
`default_nettype wire

// ----- design/spcr_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one result bit per stage.
`default_nettype none
module spcr_sqrt (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  spcr_pkg::spcr_item_t     in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output spcr_pkg::spcr_item_t     out_item
);
	import spcr_pkg::*;

	localparam int Depth = RootBits;

	logic [Depth-1:0] vld_s;
	logic [Depth-1:0] en;
	spcr_item_t       itm_s [Depth];
	logic [18:0]      rem_s [Depth];
	logic [16:0]      root_s [Depth];

	always_comb begin
		en[Depth-1] = !vld_s[Depth-1] || out_ready;
		for (int k = Depth - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < Depth; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	for (genvar k = 0; k < Depth; k++) begin : g_step
		localparam int Hi = 2 * Depth - 1 - 2 * k;
		spcr_item_t  p_itm;
		logic [18:0] p_rem;
		logic [16:0] p_root;
		logic [33:0] radx;
		logic [20:0] cur;
		logic [20:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign p_itm  = in_item;
			assign p_rem  = '0;
			assign p_root = '0;
		end else begin : g_next
			assign p_itm  = itm_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
		end

		assign radx  = {1'b0, p_itm.rad};
		assign cur   = {p_rem, radx[Hi -: 2]};
		assign trial = {2'b00, p_root, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				itm_s[k]  <= p_itm;
				rem_s[k]  <= ge ? 19'(cur - trial) : cur[18:0];
				root_s[k] <= {p_root[15:0], ge};
			end
		end
	end

	assign out_valid = vld_s[Depth-1];

	always_comb begin
		out_item    = itm_s[Depth-1];
		out_item.zw = root_s[Depth-1];
	end

	// The root is the floor: its square fits and the next square does not.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (34'(root_s[Depth-1]) * 34'(root_s[Depth-1])
		<= {1'b0, itm_s[Depth-1].rad}))
		else $error("square root too large");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((34'(root_s[Depth-1]) + 34'd1) * (34'(root_s[Depth-1]) + 34'd1)
		> {1'b0, itm_s[Depth-1].rad}))
		else $error("square root too small");

endmodule
`default_nettype wire

// ----- design/spherical_camera_ray_gen.sv -----
// Top level of the spherical camera ray generator: config, arithmetic stages and output.
`default_nettype none
// Accepts one pixel sample per clock while the output is not stalled and returns one
// ray per sample (one input stage, 19 divider stages, seven mapping and sine stages,
// 17 square root stages and the output register). The pipeline advances stage by stage,
// so bubbles close up when the output stalls. The divider and the square root each retire
// one result bit per stage. The user must write configuration only while idle; the block does not enforce it.
module spherical_camera_ray_gen #(
	parameter int COORD_BITS = spcr_pkg::CoordBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] packed_pixel,
	input  wire logic [15:0] jitter_x,
	input  wire logic [15:0] jitter_y,
	input  wire logic [15:0] time_random,
	input  wire logic [15:0] wave_random,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      ray_dir_x,
	output logic [15:0]      ray_dir_y,
	output logic [15:0]      ray_dir_z,
	output logic             ray_from_origin,
	output logic [15:0]      out_pixel_x,
	output logic [15:0]      out_pixel_y,
	output logic [15:0]      time_sample,
	output logic [16:0]      wave_sample
);
	import spcr_pkg::*;

	mode_t       mode_q;
	logic [15:0] frame_width_q;
	logic [15:0] frame_height_q;
	logic [15:0] win_x_q;
	logic [15:0] win_y_q;
	logic        motion_blur_q;
	logic        spectral_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= ModeHemi;
			frame_width_q  <= 16'd1;
			frame_height_q <= 16'd1;
			win_x_q        <= '0;
			win_y_q        <= '0;
			motion_blur_q  <= 1'b0;
			spectral_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				RegMode:       mode_q         <= mode_t'(cfg_wdata[2:0]);
				RegWidth:      frame_width_q  <= cfg_wdata;
				RegHeight:     frame_height_q <= cfg_wdata;
				RegWinX:       win_x_q        <= cfg_wdata;
				RegWinY:       win_y_q        <= cfg_wdata;
				RegMotionBlur: motion_blur_q  <= cfg_wdata[0];
				RegSpectral:   spectral_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic [15:0] size_x;
	logic [15:0] size_y;
	assign size_x = (frame_width_q == '0) ? 16'd1 : frame_width_q;
	assign size_y = (frame_height_q == '0) ? 16'd1 : frame_height_q;

	// Handshake chain.
	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic       en1, en2, en3, en4, en5, en6, en7, en8, en9;
	logic       div_in_ready, div_out_valid, sq_in_ready, sq_out_valid;
	spcr_item_t div_item, sq_item;
	spcr_item_t itm_s1, itm_s2, itm_s3, itm_s4, itm_s5, itm_s6, itm_s7, itm_s8;
	spcr_item_t nxt1, nxt2, nxt3, nxt4, nxt5, nxt6, nxt7, nxt8;

	assign en9      = !vld_s9 || out_ready;
	assign en8      = !vld_s8 || sq_in_ready;
	assign en7      = !vld_s7 || en8;
	assign en6      = !vld_s6 || en7;
	assign en5      = !vld_s5 || en6;
	assign en4      = !vld_s4 || en5;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || div_in_ready;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= div_out_valid;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
			if (en8) vld_s8 <= vld_s7;
			if (en9) vld_s9 <= sq_out_valid;
		end
	end

	// Stage 1: unpack the pixel and form the division numerators.
	logic [15:0] px_c, py_c;
	assign px_c = 16'(packed_pixel[COORD_BITS-1:0]);
	assign py_c = 16'(packed_pixel[16 +: COORD_BITS]);

	always_comb begin
		nxt1       = '0;
		nxt1.px    = px_c;
		nxt1.py    = py_c;
		nxt1.tsamp = motion_blur_q ? time_random : 16'd0;
		nxt1.wsamp = spectral_q ? {1'b0, wave_random} : OneQ16;
		nxt1.num_x = {17'(px_c) + 17'(win_x_q), 16'd0} + 33'(jitter_x);
		nxt1.num_y = {17'(py_c) + 17'(win_y_q), 16'd0} + 33'(jitter_y);
	end

	always_ff @(posedge clk) begin
		if (en1) itm_s1 <= nxt1;
	end

	spcr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (div_in_ready),
		.in_item   (itm_s1),
		.size_x    (size_x),
		.size_y    (size_y),
		.out_valid (div_out_valid),
		.out_ready (en2),
		.out_item  (div_item)
	);

	// Stage 2: fisheye weights and panorama angle reduction.
	logic               back_c;
	logic [17:0]        xsh_c;
	logic [18:0]        xv_c;
	logic signed [20:0] xw_c, yw_c;
	logic [16:0]        theta_c, phi_c;
	logic [3:0][16:0]   ang_c;

	always_comb begin
		back_c  = (mode_q == ModeSphere) && (div_item.xn > 18'd32768);
		xsh_c   = back_c ? 18'(div_item.xn - 18'd32768) : div_item.xn;
		xv_c    = (mode_q == ModeSphere) ? {xsh_c, 1'b0} : {1'b0, div_item.xn};
		xw_c    = $signed({1'b0, xv_c, 1'b0}) - 21'sd65536;
		yw_c    = $signed({2'b00, div_item.yn, 1'b0}) - 21'sd65536;
		theta_c = 17'(OneQ16 - div_item.yn[16:0]);
		phi_c   = (mode_q == ModePanoHemi) ? 17'(div_item.xn[16:0] + OneQ16)
		                                   : {div_item.xn[15:0], 1'b0};
		ang_c[0] = theta_c;
		ang_c[1] = 17'(theta_c + 17'h8000);
		ang_c[2] = phi_c;
		ang_c[3] = 17'(phi_c + 17'h8000);
		nxt2      = div_item;
		nxt2.back = back_c;
		nxt2.oob  = (xw_c >= 21'sd65536) || (xw_c <= -21'sd65536)
		         || (yw_c >= 21'sd65536) || (yw_c <= -21'sd65536);
		nxt2.xw   = 18'(xw_c);
		nxt2.yw   = 18'(yw_c);
		for (int i = 0; i < 4; i++) begin
			{nxt2.neg[i], nxt2.z[i]} = turn_reduce(ang_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) itm_s2 <= nxt2;
	end

	// Stage 3: squares.
	logic signed [17:0] xw2, yw2;
	logic [15:0]        ax_c, ay_c;

	always_comb begin
		xw2  = $signed(itm_s2.xw);
		yw2  = $signed(itm_s2.yw);
		ax_c = xw2[17] ? 16'(-xw2) : xw2[15:0];
		ay_c = yw2[17] ? 16'(-yw2) : yw2[15:0];
		nxt3     = itm_s2;
		nxt3.sqx = 32'(ax_c) * 32'(ax_c);
		nxt3.sqy = 32'(ay_c) * 32'(ay_c);
		for (int i = 0; i < 4; i++) begin
			nxt3.z2[i] = 17'((34'(itm_s2.z[i]) * 34'(itm_s2.z[i])) >> 16);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) itm_s3 <= nxt3;
	end

	// Stage 4: disc test and first polynomial term.
	logic [32:0] r2_c;

	always_comb begin
		r2_c         = 33'(itm_s3.sqx) + 33'(itm_s3.sqy);
		nxt4         = itm_s3;
		nxt4.in_disc = !itm_s3.oob && !r2_c[32];
		nxt4.rad     = 33'h1_0000_0000 - r2_c;
		for (int i = 0; i < 4; i++) begin
			nxt4.p[i] = 17'(SinC5 - 17'((34'(itm_s3.z2[i]) * 34'(SinC7)) >> 16));
		end
	end

	always_ff @(posedge clk) begin
		if (en4) itm_s4 <= nxt4;
	end

	always_comb begin
		nxt5 = itm_s4;
		for (int i = 0; i < 4; i++) begin
			nxt5.p[i] = 17'(SinC3 - 17'((34'(itm_s4.z2[i]) * 34'(itm_s4.p[i])) >> 16));
		end
	end

	always_ff @(posedge clk) begin
		if (en5) itm_s5 <= nxt5;
	end

	always_comb begin
		nxt6 = itm_s5;
		for (int i = 0; i < 4; i++) begin
			nxt6.p[i] = 17'(SinC1 - 17'((34'(itm_s5.z2[i]) * 34'(itm_s5.p[i])) >> 16));
		end
	end

	always_ff @(posedge clk) begin
		if (en6) itm_s6 <= nxt6;
	end

	// Stage 7: finish the sines and apply the half-turn sign.
	logic [3:0][16:0] s_c;

	always_comb begin
		nxt7 = itm_s6;
		for (int i = 0; i < 4; i++) begin
			s_c[i]     = 17'((34'(itm_s6.z[i]) * 34'(itm_s6.p[i])) >> 16);
			nxt7.sn[i] = itm_s6.neg[i] ? 18'(-{1'b0, s_c[i]}) : {1'b0, s_c[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en7) itm_s7 <= nxt7;
	end

	// Stage 8: sin(theta) times cos(phi) and sin(phi).
	always_comb begin
		nxt8        = itm_s7;
		nxt8.prod_x = 36'($signed(itm_s7.sn[0]) * $signed(itm_s7.sn[3]));
		nxt8.prod_y = 36'($signed(itm_s7.sn[0]) * $signed(itm_s7.sn[2]));
	end

	always_ff @(posedge clk) begin
		if (en8) itm_s8 <= nxt8;
	end

	spcr_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s8),
		.in_ready  (sq_in_ready),
		.in_item   (itm_s8),
		.out_valid (sq_out_valid),
		.out_ready (en9),
		.out_item  (sq_item)
	);

	// Output stage: round, saturate and pick the projection.
	logic signed [23:0] fx_c, fy_c, fz_c, pxd_c, pyd_c, pzd_c;
	logic signed [36:0] prx_c, pry_c;
	logic signed [18:0] zs_c;
	logic [15:0]        dx_c, dy_c, dz_c;
	logic               org_c;

	always_comb begin
		fx_c  = 24'($signed(sq_item.xw) + 18'sd1) >>> 1;
		fy_c  = 24'($signed(sq_item.yw) + 18'sd1) >>> 1;
		zs_c  = sq_item.back ? $signed({2'b00, sq_item.zw}) : -$signed({2'b00, sq_item.zw});
		fz_c  = 24'(zs_c + 19'sd1) >>> 1;
		prx_c = (37'($signed(sq_item.prod_x)) + 37'sd65536) >>> 17;
		pry_c = (37'($signed(sq_item.prod_y)) + 37'sd65536) >>> 17;
		pxd_c = 24'(prx_c);
		pyd_c = 24'(pry_c);
		pzd_c = 24'($signed(sq_item.sn[1]) + 18'sd1) >>> 1;
		dx_c  = 16'd0;
		dy_c  = 16'h8000;
		dz_c  = 16'd0;
		org_c = 1'b0;
		case (mode_q)
			ModeHemi, ModeSphere: begin
				if (sq_item.in_disc) begin
					dx_c  = sat_q15(fx_c);
					dy_c  = sat_q15(fy_c);
					dz_c  = sat_q15(fz_c);
					org_c = 1'b1;
				end
			end
			ModePanoHemi, ModePanoSphere: begin
				dx_c  = sat_q15(pxd_c);
				dy_c  = sat_q15(pyd_c);
				dz_c  = sat_q15(pzd_c);
				org_c = 1'b1;
			end
			default: ;
		endcase
	end

	logic [15:0] dx_s9, dy_s9, dz_s9, px_s9, py_s9, ts_s9;
	logic [16:0] ws_s9;
	logic        org_s9;

	always_ff @(posedge clk) begin
		if (en9) begin
			dx_s9  <= dx_c;
			dy_s9  <= dy_c;
			dz_s9  <= dz_c;
			org_s9 <= org_c;
			px_s9  <= sq_item.px;
			py_s9  <= sq_item.py;
			ts_s9  <= sq_item.tsamp;
			ws_s9  <= sq_item.wsamp;
		end
	end

	assign out_valid       = vld_s9;
	assign ray_dir_x       = dx_s9;
	assign ray_dir_y       = dy_s9;
	assign ray_dir_z       = dz_s9;
	assign ray_from_origin = org_s9;
	assign out_pixel_x     = px_s9;
	assign out_pixel_y     = py_s9;
	assign time_sample     = ts_s9;
	assign wave_sample     = ws_s9;

	// A ray that does not start at the origin is always the downward default ray.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ray_from_origin |->
		ray_dir_x == 16'd0 && ray_dir_y == 16'h8000 && ray_dir_z == 16'd0)
		else $error("default ray has wrong direction");

	// Panorama modes never fall back to the default ray.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode_q == ModePanoHemi || mode_q == ModePanoSphere) |-> ray_from_origin)
		else $error("panorama ray marked as default");

	// A beat held at the output keeps its position in the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && !out_ready |=> vld_s9 && $stable(out_pixel_x) && $stable(out_pixel_y))
		else $error("stalled output beat changed");

endmodule
`default_nettype wire
